@@ hdl/polyline_plane_crossing_finder_top_macros.svh @@
// assertion macros for the polyline plane crossing finder
// expects signals named clk and rst in the including module
`ifndef POLYLINE_PLANE_CROSSING_FINDER_TOP_MACROS_SVH
`define POLYLINE_PLANE_CROSSING_FINDER_TOP_MACROS_SVH

// same-cycle implication
`define PPCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ppcf_pkg.sv @@
// shared types, constants and width helpers for the crossing finder
// no dependencies
package ppcf_pkg;

  localparam int NORM_W     = 18;
  localparam int OFFSET_W   = 32;
  localparam int THRESH_W   = 31;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;

  localparam logic signed [NORM_W-1:0]   NORMAL_X_RST = 18'sd0;
  localparam logic signed [NORM_W-1:0]   NORMAL_Y_RST = 18'sd0;
  localparam logic signed [NORM_W-1:0]   NORMAL_Z_RST = 18'sd65536;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST   = 32'sd0;
  localparam logic [THRESH_W-1:0]        THRESH_RST   = 31'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_X   = 3'd0,
    CFG_NORMAL_Y   = 3'd1,
    CFG_NORMAL_Z   = 3'd2,
    CFG_OFFSET     = 3'd3,
    CFG_THRESHOLD  = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_SUM,
    S_DIST,
    S_EVAL,
    S_MD_LOAD,
    S_MUL,
    S_DIV_LOAD,
    S_DIV,
    S_WRITE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       prod;
    logic       sum;
    logic       dist_calc;
    logic       latch_end;
    logic       md_load;
    logic       mul_step;
    logic       div_load;
    logic       div_step;
    logic       write;
    logic       advance;
    logic       load_out;
    logic       found;
    logic [1:0] axis;
  } ctrl_cmd_t;

  typedef struct packed {
    logic crosses;
    logic grazes;
    logic interp;
    logic last;
  } dp_status_t;

  // width of the signed plane distance
  function automatic int dist_width(int cw, int frac);
    int sh;
    sh = NORM_W + cw + 2 - frac;
    return ((sh > OFFSET_W) ? sh : OFFSET_W) + 1;
  endfunction

endpackage

@@ hdl/ppcf_ctrl.sv @@
// sequencing state machine for the crossing finder
// depends on ppcf_pkg and the assertion macro header
`include "polyline_plane_crossing_finder_top_macros.svh"

module ppcf_ctrl
  import ppcf_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       point_valid,
  output logic       point_stall,
  output logic       hit_valid,
  input  logic       hit_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam int DIST_W   = dist_width(COORD_WIDTH, FRAC_BITS);
  localparam int QW       = COORD_WIDTH + 1;
  localparam int STEP_MAX = (DIST_W > QW) ? DIST_W : QW;
  localparam int CNT_W    = $clog2(STEP_MAX);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       axis;
  logic             have_prev;
  logic             hit_latched;

  logic eval_hit;
  logic out_free;
  logic mul_end;
  logic div_end;
  logic poly_end;

  assign eval_hit = have_prev && !hit_latched && (status.crosses || status.grazes);
  assign out_free = !hit_valid || !hit_stall;
  assign mul_end  = (cnt == CNT_W'(DIST_W - 1));
  assign div_end  = (cnt == CNT_W'(QW - 1));
  assign poly_end = (state == S_FINISH) && status.last && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (point_valid) state_next = S_PROD;
      S_PROD:     state_next = S_SUM;
      S_SUM:      state_next = S_DIST;
      S_DIST:     state_next = S_EVAL;
      S_EVAL:     state_next = (eval_hit && status.interp) ? S_MD_LOAD : S_FINISH;
      S_MD_LOAD:  state_next = S_MUL;
      S_MUL:      if (mul_end) state_next = S_DIV_LOAD;
      S_DIV_LOAD: state_next = S_DIV;
      S_DIV:      if (div_end) state_next = S_WRITE;
      S_WRITE:    state_next = (axis == 2'd2) ? S_FINISH : S_MD_LOAD;
      S_FINISH:   if (!status.last || out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.axis    = axis;
    cmd.found   = hit_latched;
    point_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        point_stall = 1'b0;
        cmd.capture = point_valid;
      end
      S_PROD:     cmd.prod = 1'b1;
      S_SUM:      cmd.sum = 1'b1;
      S_DIST:     cmd.dist_calc = 1'b1;
      S_EVAL:     cmd.latch_end = eval_hit && !status.interp;
      S_MD_LOAD:  cmd.md_load = 1'b1;
      S_MUL:      cmd.mul_step = 1'b1;
      S_DIV_LOAD: cmd.div_load = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_WRITE:    cmd.write = 1'b1;
      S_FINISH: begin
        cmd.advance  = 1'b1;
        cmd.load_out = status.last && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      axis        <= 2'd0;
      have_prev   <= 1'b0;
      hit_latched <= 1'b0;
      hit_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if ((state == S_MUL && !mul_end) || (state == S_DIV && !div_end)) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end

      if (state == S_EVAL) begin
        axis <= 2'd0;
      end else if (state == S_WRITE) begin
        axis <= axis + 2'd1;
      end

      if (state == S_EVAL && eval_hit) begin
        hit_latched <= 1'b1;
      end else if (poly_end) begin
        hit_latched <= 1'b0;
      end

      if (poly_end) begin
        have_prev <= 1'b0;
      end else if (state == S_FINISH) begin
        have_prev <= 1'b1;
      end

      if (cmd.load_out) begin
        hit_valid <= 1'b1;
      end else if (!hit_stall) begin
        hit_valid <= 1'b0;
      end
    end
  end

  `PPCF_ASSERT_NOW(a_no_overwrite, cmd.load_out, !hit_valid || !hit_stall, "pending result overwritten")
  `PPCF_ASSERT_NEXT(a_capture_start, cmd.capture, state == S_PROD, "capture did not start a pass")
  `PPCF_ASSERT_NOW(a_hit_needs_prev, hit_latched, have_prev, "hit latched without a segment")
  `PPCF_ASSERT_NEXT(a_last_axis, state == S_WRITE && axis == 2'd2, state == S_FINISH, "axis overrun")

endmodule

@@ hdl/ppcf_datapath.sv @@
// configuration registers, plane distance, segment test and shared mul-div unit
// depends on ppcf_pkg
module ppcf_datapath
  import ppcf_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic                          last_point,
  input  ctrl_cmd_t                     cmd,
  output dp_status_t                    status,
  output logic                          hit_found,
  output logic signed [COORD_WIDTH-1:0] hit_x,
  output logic signed [COORD_WIDTH-1:0] hit_y,
  output logic signed [COORD_WIDTH-1:0] hit_z
);

  localparam int PROD_W = NORM_W + COORD_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SH_W   = SUM_W - FRAC_BITS;
  localparam int DIST_W = dist_width(COORD_WIDTH, FRAC_BITS);
  localparam int DEN_W  = DIST_W + 1;
  localparam int QW     = COORD_WIDTH + 1;
  localparam int PW     = QW + DIST_W;

  logic signed [NORM_W-1:0]   normal_x, normal_y, normal_z;
  logic signed [OFFSET_W-1:0] plane_offset;
  logic [THRESH_W-1:0]        near_threshold;

  logic signed [COORD_WIDTH-1:0] cur_p     [3];
  logic signed [COORD_WIDTH-1:0] prev_p    [3];
  logic signed [COORD_WIDTH-1:0] latched_p [3];
  logic                          cur_last;

  logic signed [PROD_W-1:0] prod [3];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SH_W-1:0]   sum_sh;
  logic signed [DIST_W-1:0] dist_cur, dist_prev;

  logic [DIST_W-1:0]       a0, a1, thr;
  logic signed [DEN_W-1:0] diff;
  logic [DEN_W-1:0]        den_c;
  logic                    d0_le, d0_ge, d1_le, d1_ge;

  logic [DEN_W-1:0]        md_den;
  logic [DIST_W-1:0]       md_mul;
  logic [QW-1:0]           md_dp;
  logic                    md_neg;
  logic [PW-1:0]           md_acc;
  logic [DEN_W-1:0]        md_rem;
  logic [QW-1:0]           md_q;

  logic signed [QW-1:0]    dp_c;
  logic [DEN_W:0]          trial;
  logic                    trial_ge;
  logic [QW-1:0]           base;
  logic [QW-1:0]           res;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x       <= NORMAL_X_RST;
      normal_y       <= NORMAL_Y_RST;
      normal_z       <= NORMAL_Z_RST;
      plane_offset   <= OFFSET_RST;
      near_threshold <= THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NORMAL_X:  normal_x       <= cfg_data[NORM_W-1:0];
        CFG_NORMAL_Y:  normal_y       <= cfg_data[NORM_W-1:0];
        CFG_NORMAL_Z:  normal_z       <= cfg_data[NORM_W-1:0];
        CFG_OFFSET:    plane_offset   <= cfg_data[OFFSET_W-1:0];
        CFG_THRESHOLD: near_threshold <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // segment test
  assign sum_sh = sum[SUM_W-1:FRAC_BITS];
  assign a0     = DIST_W'(dist_prev[DIST_W-1] ? -dist_prev : dist_prev);
  assign a1     = DIST_W'(dist_cur[DIST_W-1] ? -dist_cur : dist_cur);
  assign thr    = DIST_W'(near_threshold);
  assign diff   = DEN_W'(dist_prev) - DEN_W'(dist_cur);
  assign den_c  = DEN_W'(diff[DEN_W-1] ? -diff : diff);
  assign d0_le  = dist_prev[DIST_W-1] || (dist_prev == '0);
  assign d0_ge  = !dist_prev[DIST_W-1];
  assign d1_le  = dist_cur[DIST_W-1] || (dist_cur == '0);
  assign d1_ge  = !dist_cur[DIST_W-1];

  assign status.crosses = (d0_le && d1_ge) || (d0_ge && d1_le);
  assign status.grazes  = (a0 < thr) || (a1 < thr);
  assign status.interp  = status.crosses && (dist_prev != dist_cur);
  assign status.last    = cur_last;

  // mul-div helpers
  assign dp_c     = QW'(cur_p[cmd.axis]) - QW'(prev_p[cmd.axis]);
  assign trial    = {md_rem, md_q[QW-1]};
  assign trial_ge = (trial >= {1'b0, md_den});
  assign base     = QW'(prev_p[cmd.axis]);
  assign res      = md_neg ? (base - md_q) : (base + md_q);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_p[0] <= point_x;
      cur_p[1] <= point_y;
      cur_p[2] <= point_z;
      cur_last <= last_point;
    end
    if (cmd.prod) begin
      prod[0] <= PROD_W'(normal_x) * PROD_W'(cur_p[0]);
      prod[1] <= PROD_W'(normal_y) * PROD_W'(cur_p[1]);
      prod[2] <= PROD_W'(normal_z) * PROD_W'(cur_p[2]);
    end
    if (cmd.sum) begin
      sum <= SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
    end
    if (cmd.dist_calc) begin
      dist_cur <= DIST_W'(sum_sh) - DIST_W'(plane_offset);
    end
    if (cmd.latch_end) begin
      for (int i = 0; i < 3; i++) begin
        latched_p[i] <= (a0 < a1) ? prev_p[i] : cur_p[i];
      end
    end
    if (cmd.md_load) begin
      md_den <= den_c;
      md_mul <= a0;
      md_neg <= dp_c[QW-1];
      md_dp  <= QW'(dp_c[QW-1] ? -dp_c : dp_c);
      md_acc <= '0;
    end
    if (cmd.mul_step) begin
      md_acc <= (md_acc << 1) + (md_mul[DIST_W-1] ? PW'(md_dp) : PW'(0));
      md_mul <= md_mul << 1;
    end
    if (cmd.div_load) begin
      md_rem <= DEN_W'(md_acc[PW-1:QW]);
      md_q   <= md_acc[QW-1:0];
    end
    if (cmd.div_step) begin
      md_rem <= trial_ge ? DEN_W'(trial - {1'b0, md_den}) : DEN_W'(trial);
      md_q   <= {md_q[QW-2:0], trial_ge};
    end
    if (cmd.write) begin
      latched_p[cmd.axis] <= res[COORD_WIDTH-1:0];
    end
    if (cmd.advance) begin
      prev_p    <= cur_p;
      dist_prev <= dist_cur;
    end
    if (cmd.load_out) begin
      hit_found <= cmd.found;
      hit_x     <= cmd.found ? latched_p[0] : '0;
      hit_y     <= cmd.found ? latched_p[1] : '0;
      hit_z     <= cmd.found ? latched_p[2] : '0;
    end
  end

endmodule

@@ hdl/polyline_plane_crossing_finder_top.sv @@
// top level of the polyline plane crossing finder
// depends on ppcf_pkg, ppcf_ctrl and ppcf_datapath
//
// Vertices enter on the point channel (point_valid / point_stall), one
// transaction per vertex, last_point set on the final vertex of a polyline.
// One result per polyline leaves on the hit channel (hit_valid / hit_stall)
// after the transaction that carried last_point.
// Plane registers are written on the cfg channel (cfg_valid / cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high, write only while idle.
// Each vertex passes through capture, three registered multiplies, sum,
// distance, segment test and commit. A segment that needs interpolation
// adds a pass per axis, axis after axis, through one shared shift-add
// multiplier and restoring divider, one bit per cycle; this happens at most
// once per polyline.
// The result of a last vertex is registered from its commit step once the output is free.
// A stalled result is held; the next vertices are still processed, and only
// the next last vertex waits until the pending result is taken.
// Reset (rst, synchronous) restores register defaults and starts a new polyline.
module polyline_plane_crossing_finder_top
  import ppcf_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          point_valid,
  output logic                          point_stall,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic                          last_point,
  output logic                          hit_valid,
  input  logic                          hit_stall,
  output logic                          hit_found,
  output logic signed [COORD_WIDTH-1:0] hit_x,
  output logic signed [COORD_WIDTH-1:0] hit_y,
  output logic signed [COORD_WIDTH-1:0] hit_z
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  ppcf_ctrl #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .hit_valid   (hit_valid),
    .hit_stall   (hit_stall),
    .status      (status),
    .cmd         (cmd)
  );

  ppcf_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .last_point (last_point),
    .cmd        (cmd),
    .status     (status),
    .hit_found  (hit_found),
    .hit_x      (hit_x),
    .hit_y      (hit_y),
    .hit_z      (hit_z)
  );

endmodule
